// ===== rtl/core/tsfd_pkg.sv =====
package tsfd_pkg;

  localparam int FRAME_LEN = 59;
  localparam int POS_W = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] SYNC_LIMIT_RST = 8'd3;
  localparam logic [7:0] ONE_LIMIT_RST = 8'd30;
  localparam logic [7:0] MINUTE_LIMIT = 8'd60;
  localparam logic [7:0] HOUR_LIMIT = 8'd24;

  localparam int MINUTE_PARITY = 28;
  localparam int HOUR_PARITY = 35;
  localparam int DATE_PARITY = 58;

  typedef enum logic [1:0] {
    SYM_ZERO = 2'd0,
    SYM_ONE  = 2'd1,
    SYM_SYNC = 2'd2,
    SYM_ERR  = 2'd3
  } sym_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_LIMIT  = 2'd0,
    REG_ONE_LIMIT   = 2'd1,
    REG_DATE_PARITY = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        frame_done;
    logic        frame_ok;
    logic [13:0] weather_bits;
    logic [6:0]  minute_value;
    logic [5:0]  hour_value;
    logic [5:0]  day_value;
    logic [2:0]  weekday_value;
    logic [4:0]  month_value;
    logic [7:0]  year_value;
    logic [3:0]  status_flags;
  } result_t;

  typedef struct packed {
    sym_t             sym;
    logic [POS_W-1:0] pos;
    logic             decode;
  } frame_stat_t;

  // weights 1,2,4,8 on the low nibble, 10,20,40,80 on the high nibble
  function automatic logic [7:0] bcd_weigh(input logic [7:0] bits);
    logic [7:0] tens;
    tens = {4'd0, bits[7:4]};
    return {4'd0, bits[3:0]} + 8'((tens << 3) + (tens << 1));
  endfunction

endpackage

// ===== rtl/core/tsfd_pulse_if.sv =====
interface tsfd_pulse_if;
  logic       valid;
  logic       ready;
  logic [7:0] pulse_ticks;

  modport source (output valid, output pulse_ticks, input ready);
  modport sink (input valid, input pulse_ticks, output ready);
endinterface

// ===== rtl/core/tsfd_result_if.sv =====
interface tsfd_result_if;
  logic        valid;
  logic        ready;
  logic        frame_done;
  logic        frame_ok;
  logic [13:0] weather_bits;
  logic [6:0]  minute_value;
  logic [5:0]  hour_value;
  logic [5:0]  day_value;
  logic [2:0]  weekday_value;
  logic [4:0]  month_value;
  logic [7:0]  year_value;
  logic [3:0]  status_flags;

  modport source (
    output valid, output frame_done, output frame_ok, output weather_bits,
    output minute_value, output hour_value, output day_value, output weekday_value,
    output month_value, output year_value, output status_flags, input ready
  );
  modport sink (
    input valid, input frame_done, input frame_ok, input weather_bits,
    input minute_value, input hour_value, input day_value, input weekday_value,
    input month_value, input year_value, input status_flags, output ready
  );
endinterface

// ===== rtl/core/tsfd_cfg_if.sv =====
interface tsfd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tsfd_pkg::CFG_IDX_W-1:0]  index;
  logic [tsfd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/time_signal_frame_decoder.sv =====
// channel   dir  payload                                  accepted when
// pulse     in   pulse_ticks                              valid && ready
// result    out  frame_done .. status_flags (10 fields)   valid && ready
// cfg       in   index, data                              valid && ready (ready always 1)
//
// One pulse is taken per cycle while the output register is empty or being drained; its
// result is written into the output register as the pulse is taken. Symbol classification
// and the decode of the stored frame are combinational and feed the result register.
// A new pulse is taken whenever the output register is empty or being drained.
// rst clears the frame position and the result valid flag and sets the limits to their reset values.
module time_signal_frame_decoder (
  input  logic          clk,
  input  logic          rst,
  tsfd_pulse_if.sink    pulse_in,
  tsfd_result_if.source result_out,
  tsfd_cfg_if.sink      cfg
);

  logic [7:0]             sync_limit;
  logic [7:0]             one_limit;
  logic                   date_parity_enable;
  logic                   accept;
  logic                   out_valid;
  tsfd_pkg::sym_t         frame [tsfd_pkg::FRAME_LEN];
  tsfd_pkg::frame_stat_t  stat;
  tsfd_pkg::result_t      dec_res;
  tsfd_pkg::result_t      res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_limit <= tsfd_pkg::SYNC_LIMIT_RST;
      one_limit <= tsfd_pkg::ONE_LIMIT_RST;
      date_parity_enable <= 1'b0;
    end else if (cfg.valid) begin
      unique case (tsfd_pkg::cfg_reg_t'(cfg.index))
        tsfd_pkg::REG_SYNC_LIMIT:  sync_limit <= cfg.data;
        tsfd_pkg::REG_ONE_LIMIT:   one_limit <= cfg.data;
        tsfd_pkg::REG_DATE_PARITY: date_parity_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign pulse_in.ready = !out_valid || result_out.ready;
  assign accept = pulse_in.valid && pulse_in.ready;

  tsfd_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .pulse_ticks (pulse_in.pulse_ticks),
    .sync_limit  (sync_limit),
    .one_limit   (one_limit),
    .frame       (frame),
    .stat        (stat)
  );

  tsfd_decode u_decode (
    .frame              (frame),
    .date_parity_enable (date_parity_enable),
    .res                (dec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= stat.decode ? dec_res : '0;
    end
  end

  assign result_out.valid         = out_valid;
  assign result_out.frame_done    = res.frame_done;
  assign result_out.frame_ok      = res.frame_ok;
  assign result_out.weather_bits  = res.weather_bits;
  assign result_out.minute_value  = res.minute_value;
  assign result_out.hour_value    = res.hour_value;
  assign result_out.day_value     = res.day_value;
  assign result_out.weekday_value = res.weekday_value;
  assign result_out.month_value   = res.month_value;
  assign result_out.year_value    = res.year_value;
  assign result_out.status_flags  = res.status_flags;

  a_ok_needs_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.frame_ok |-> res.frame_done)
    else $error("frame_ok without frame_done");

  a_bad_frame_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.frame_ok |-> res.weather_bits == '0 && res.status_flags == '0 &&
      res.minute_value == '0 && res.year_value == '0)
    else $error("fields set on a frame without good markers");

  a_sync_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && stat.sym == tsfd_pkg::SYM_SYNC |=> stat.pos == '0)
    else $error("sync did not restart the frame");

  a_done_needs_full: assert property (@(posedge clk) disable iff (rst)
    accept && stat.decode |-> stat.pos == tsfd_pkg::POS_W'(tsfd_pkg::FRAME_LEN))
    else $error("decode on a frame that is not full");

endmodule

// ===== rtl/core/tsfd_frame.sv =====
module tsfd_frame (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            pulse_ticks,
  input  logic [7:0]            sync_limit,
  input  logic [7:0]            one_limit,
  output tsfd_pkg::sym_t        frame [tsfd_pkg::FRAME_LEN],
  output tsfd_pkg::frame_stat_t stat
);

  tsfd_pkg::sym_t             sym;
  logic [tsfd_pkg::POS_W-1:0] pos;
  logic [tsfd_pkg::POS_W-1:0] pos_next;
  logic                       full;

  always_comb begin
    priority if (pulse_ticks > sync_limit && pulse_ticks < one_limit) begin
      sym = tsfd_pkg::SYM_ZERO;
    end else if (pulse_ticks > one_limit) begin
      sym = tsfd_pkg::SYM_ONE;
    end else if (pulse_ticks < sync_limit) begin
      sym = tsfd_pkg::SYM_SYNC;
    end else begin
      sym = tsfd_pkg::SYM_ERR;
    end
  end

  assign full = (pos == tsfd_pkg::POS_W'(tsfd_pkg::FRAME_LEN));

  always_comb begin
    if (sym == tsfd_pkg::SYM_SYNC) begin
      pos_next = '0;
    end else if (full) begin
      // overlong frame: this symbol becomes symbol 0
      pos_next = tsfd_pkg::POS_W'(1);
    end else begin
      pos_next = pos + tsfd_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= pos_next;
    end
  end

  // symbols shift in from the top, so after a full frame entry k is symbol k
  always_ff @(posedge clk) begin
    if (accept && sym != tsfd_pkg::SYM_SYNC) begin
      for (int i = 0; i < tsfd_pkg::FRAME_LEN - 1; i++) begin
        frame[i] <= frame[i+1];
      end
      frame[tsfd_pkg::FRAME_LEN-1] <= sym;
    end
  end

  assign stat.sym = sym;
  assign stat.pos = pos;
  assign stat.decode = (sym == tsfd_pkg::SYM_SYNC) && full;

endmodule

// ===== rtl/core/tsfd_decode.sv =====
module tsfd_decode (
  input  tsfd_pkg::sym_t   frame [tsfd_pkg::FRAME_LEN],
  input  logic             date_parity_enable,
  output tsfd_pkg::result_t res
);

  logic [tsfd_pkg::FRAME_LEN-1:0] bitv;
  logic [tsfd_pkg::FRAME_LEN-1:0] dirty;
  logic       frame_ok;
  logic       min_par_ok;
  logic       hour_par_ok;
  logic       date_par_ok;
  logic       date_ok;
  logic [7:0] min_v;
  logic [7:0] hour_v;

  always_comb begin
    for (int i = 0; i < tsfd_pkg::FRAME_LEN; i++) begin
      bitv[i]  = (frame[i] == tsfd_pkg::SYM_ONE);
      dirty[i] = (frame[i] == tsfd_pkg::SYM_SYNC) || (frame[i] == tsfd_pkg::SYM_ERR);
    end
  end

  assign frame_ok = (frame[0] == tsfd_pkg::SYM_ZERO) && (frame[20] == tsfd_pkg::SYM_ONE);

  assign min_par_ok = !(|dirty[27:21]) &&
    (frame[tsfd_pkg::MINUTE_PARITY] ==
     ((^bitv[27:21]) ? tsfd_pkg::SYM_ONE : tsfd_pkg::SYM_ZERO));
  assign hour_par_ok = !(|dirty[34:29]) &&
    (frame[tsfd_pkg::HOUR_PARITY] ==
     ((^bitv[34:29]) ? tsfd_pkg::SYM_ONE : tsfd_pkg::SYM_ZERO));
  assign date_par_ok = !(|dirty[57:36]) &&
    (frame[tsfd_pkg::DATE_PARITY] ==
     ((^bitv[57:36]) ? tsfd_pkg::SYM_ONE : tsfd_pkg::SYM_ZERO));
  assign date_ok = !date_parity_enable || date_par_ok;

  assign min_v  = tsfd_pkg::bcd_weigh({1'b0, bitv[27:21]});
  assign hour_v = tsfd_pkg::bcd_weigh({2'b0, bitv[34:29]});

  always_comb begin
    res = '0;
    res.frame_done = 1'b1;
    if (frame_ok) begin
      res.frame_ok = 1'b1;
      res.weather_bits = bitv[14:1];
      res.status_flags[3] = bitv[16];
      if (min_par_ok) begin
        res.minute_value = min_v[6:0];
        res.status_flags[0] = (min_v < tsfd_pkg::MINUTE_LIMIT);
      end
      if (hour_par_ok) begin
        res.hour_value = hour_v[5:0];
        res.status_flags[1] = (hour_v < tsfd_pkg::HOUR_LIMIT);
      end
      if (date_ok) begin
        res.day_value     = 6'(tsfd_pkg::bcd_weigh({2'b0, bitv[41:36]}));
        res.weekday_value = bitv[44:42];
        res.month_value   = 5'(tsfd_pkg::bcd_weigh({3'b0, bitv[49:45]}));
        res.year_value    = tsfd_pkg::bcd_weigh(bitv[57:50]);
        res.status_flags[2] = 1'b1;
      end
    end
  end

endmodule

// ===== tb/time_signal_frame_decoder_test.sv =====
`timescale 1ns / 100ps

module time_signal_frame_decoder_test;

  class frame_decode_board;
    tsfd_pkg::sym_t             symbols[tsfd_pkg::FRAME_LEN];
    logic [tsfd_pkg::POS_W-1:0] position;
    logic [7:0]                 sync_lim;
    logic [7:0]                 one_lim;
    bit                         date_check;
    tsfd_pkg::result_t          pending[$];
    int                         mismatches;

    function new();
      foreach (symbols[i]) symbols[i] = tsfd_pkg::SYM_ZERO;
      position = '0;
      sync_lim = tsfd_pkg::SYNC_LIMIT_RST;
      one_lim = tsfd_pkg::ONE_LIMIT_RST;
      date_check = 1'b0;
      mismatches = 0;
    endfunction

    function void set_register(tsfd_pkg::cfg_reg_t idx, logic [7:0] data);
      case (idx)
        tsfd_pkg::REG_SYNC_LIMIT: sync_lim = data;
        tsfd_pkg::REG_ONE_LIMIT: one_lim = data;
        tsfd_pkg::REG_DATE_PARITY: date_check = data[0];
        default: ;
      endcase
    endfunction

    function tsfd_pkg::sym_t classify(logic [7:0] t);
      if (t > sync_lim && t < one_lim) return tsfd_pkg::SYM_ZERO;
      if (t > one_lim) return tsfd_pkg::SYM_ONE;
      if (t < sync_lim) return tsfd_pkg::SYM_SYNC;
      return tsfd_pkg::SYM_ERR;
    endfunction

    function bit is_one(int i);
      return symbols[i] == tsfd_pkg::SYM_ONE;
    endfunction

    // field holds only data symbols and its xor matches the parity symbol
    function bit clean_parity(int lo, int hi, int par);
      bit p;
      p = 1'b0;
      for (int i = lo; i <= hi; i++) begin
        if (symbols[i] == tsfd_pkg::SYM_SYNC || symbols[i] == tsfd_pkg::SYM_ERR) return 1'b0;
        p ^= is_one(i);
      end
      return symbols[par] == (p ? tsfd_pkg::SYM_ONE : tsfd_pkg::SYM_ZERO);
    endfunction

    function int weigh(int lo, int n);
      int v;
      v = 0;
      for (int k = 0; k < n; k++)
        if (is_one(lo + k)) v += (k < 4) ? (1 << k) : (10 << (k - 4));
      return v;
    endfunction

    function tsfd_pkg::result_t decode_frame();
      tsfd_pkg::result_t r;
      int v;
      r = '0;
      r.frame_done = 1'b1;
      if (!(symbols[0] == tsfd_pkg::SYM_ZERO && symbols[20] == tsfd_pkg::SYM_ONE)) return r;
      r.frame_ok = 1'b1;
      for (int i = 0; i < 14; i++) r.weather_bits[i] = is_one(i + 1);
      r.status_flags[3] = is_one(16);
      if (clean_parity(21, 27, tsfd_pkg::MINUTE_PARITY)) begin
        v = weigh(21, 7);
        r.minute_value = v[6:0];
        r.status_flags[0] = v < tsfd_pkg::MINUTE_LIMIT;
      end
      if (clean_parity(29, 34, tsfd_pkg::HOUR_PARITY)) begin
        v = weigh(29, 6);
        r.hour_value = v[5:0];
        r.status_flags[1] = v < tsfd_pkg::HOUR_LIMIT;
      end
      if (!date_check || clean_parity(36, 57, tsfd_pkg::DATE_PARITY)) begin
        v = weigh(36, 6);
        r.day_value = v[5:0];
        v = weigh(42, 3);
        r.weekday_value = v[2:0];
        v = weigh(45, 5);
        r.month_value = v[4:0];
        v = weigh(50, 8);
        r.year_value = v[7:0];
        r.status_flags[2] = 1'b1;
      end
      return r;
    endfunction

    function void note_pulse(logic [7:0] t);
      tsfd_pkg::sym_t s;
      tsfd_pkg::result_t r;
      s = classify(t);
      r = '0;
      if (s == tsfd_pkg::SYM_SYNC) begin
        if (position == tsfd_pkg::FRAME_LEN) begin
          r = decode_frame();
        end
        position = '0;
      end else begin
        // overlong frame restarts with this symbol as symbol 0
        if (position >= tsfd_pkg::FRAME_LEN) position = '0;
        symbols[position] = s;
        position++;
      end
      pending.push_back(r);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(tsfd_pkg::result_t got);
      tsfd_pkg::result_t want;
      if (pending.size() == 0) begin
        $error("result with no request pending");
        mismatches++;
        return;
      end
      want = pending.pop_front();
      compare("frame_done", want.frame_done, got.frame_done);
      compare("frame_ok", want.frame_ok, got.frame_ok);
      compare("weather_bits", want.weather_bits, got.weather_bits);
      compare("minute_value", want.minute_value, got.minute_value);
      compare("hour_value", want.hour_value, got.hour_value);
      compare("day_value", want.day_value, got.day_value);
      compare("weekday_value", want.weekday_value, got.weekday_value);
      compare("month_value", want.month_value, got.month_value);
      compare("year_value", want.year_value, got.year_value);
      compare("status_flags", want.status_flags, got.status_flags);
    endfunction
  endclass

  logic clk;
  logic rst;
  int   pulses_sent;
  wire  quiet_stretch = pulses_sent >= 400 && pulses_sent < 700;

  frame_decode_board sb = new();
  tsfd_pkg::sym_t frame_syms[tsfd_pkg::FRAME_LEN];

  tsfd_pulse_if  pulse_ch ();
  tsfd_result_if result_ch ();
  tsfd_cfg_if    cfg_ch ();

  time_signal_frame_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .pulse_in   (pulse_ch),
    .result_out (result_ch),
    .cfg        (cfg_ch)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin : result_monitor
    tsfd_pkg::result_t seen;
    if (!rst && result_ch.valid && result_ch.ready) begin
      seen.frame_done = result_ch.frame_done;
      seen.frame_ok = result_ch.frame_ok;
      seen.weather_bits = result_ch.weather_bits;
      seen.minute_value = result_ch.minute_value;
      seen.hour_value = result_ch.hour_value;
      seen.day_value = result_ch.day_value;
      seen.weekday_value = result_ch.weekday_value;
      seen.month_value = result_ch.month_value;
      seen.year_value = result_ch.year_value;
      seen.status_flags = result_ch.status_flags;
      sb.check_result(seen);
    end
  end

  // receiver: random stalls, one long hold-off while requests keep coming
  initial begin : result_sink
    bit held_off;
    held_off = 1'b0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && pulses_sent >= 150) begin
        held_off = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      result_ch.ready <= quiet_stretch || ($urandom_range(0, 99) >= 20);
    end
  end

  task automatic send_pulse(logic [7:0] t);
    if (!quiet_stretch && $urandom_range(0, 99) < 20) begin
      pulse_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    pulse_ch.valid <= 1'b1;
    pulse_ch.pulse_ticks <= t;
    do @(posedge clk); while (!pulse_ch.ready);
    sb.note_pulse(t);
    pulses_sent++;
  endtask

  task automatic drain_results();
    pulse_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(tsfd_pkg::cfg_reg_t idx, logic [7:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_register(idx, data);
  endtask

  // pulse length that lands in the wanted class under the current limits, random if none does
  function automatic logic [7:0] ticks_for(tsfd_pkg::sym_t s);
    int lo, hi, sl, ol;
    sl = sb.sync_lim;
    ol = sb.one_lim;
    lo = -1;
    hi = -1;
    case (s)
      tsfd_pkg::SYM_ZERO: if (ol > sl + 1) begin lo = sl + 1; hi = ol - 1; end
      tsfd_pkg::SYM_ONE: if (ol < 255) begin lo = ol + 1; hi = 255; end
      tsfd_pkg::SYM_SYNC: if (sl > 0) begin lo = 0; hi = (sl - 1 < ol) ? sl - 1 : ol; end
      tsfd_pkg::SYM_ERR: if (sl <= ol) begin lo = sl; hi = sl; end
      default: ;
    endcase
    if (lo < 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic tsfd_pkg::sym_t bit_sym(bit b);
    return b ? tsfd_pkg::SYM_ONE : tsfd_pkg::SYM_ZERO;
  endfunction

  function automatic void put_field(int lo, int n, logic [7:0] value);
    for (int k = 0; k < n; k++) frame_syms[lo + k] = bit_sym(value[k]);
  endfunction

  function automatic void put_parity(int lo, int hi, int par);
    bit p;
    p = $urandom_range(0, 99) < 10;
    for (int i = lo; i <= hi; i++) p ^= frame_syms[i] == tsfd_pkg::SYM_ONE;
    frame_syms[par] = bit_sym(p);
  endfunction

  // BCD field, now and then raw bits that may be out of range
  function automatic logic [7:0] bcd_field(int lo_val, int hi_val);
    int v;
    if ($urandom_range(0, 99) < 10) return 8'($urandom_range(0, 255));
    v = $urandom_range(hi_val, lo_val);
    return 8'(((v / 10) << 4) | (v % 10));
  endfunction

  function automatic void build_frame();
    for (int i = 0; i < tsfd_pkg::FRAME_LEN; i++) frame_syms[i] = bit_sym($urandom_range(0, 1));
    frame_syms[0] = tsfd_pkg::SYM_ZERO;
    frame_syms[20] = tsfd_pkg::SYM_ONE;
    put_field(21, 7, bcd_field(0, 59));
    put_parity(21, 27, tsfd_pkg::MINUTE_PARITY);
    put_field(29, 6, bcd_field(0, 23));
    put_parity(29, 34, tsfd_pkg::HOUR_PARITY);
    put_field(36, 6, bcd_field(1, 31));
    put_field(42, 3, bcd_field(1, 7));
    put_field(45, 5, bcd_field(1, 12));
    put_field(50, 8, bcd_field(0, 99));
    put_parity(36, 57, tsfd_pkg::DATE_PARITY);
    if ($urandom_range(0, 99) < 5)
      frame_syms[0] = $urandom_range(0, 1) ? tsfd_pkg::SYM_ONE : tsfd_pkg::SYM_ERR;
    if ($urandom_range(0, 99) < 5) frame_syms[20] = tsfd_pkg::SYM_ZERO;
    if ($urandom_range(0, 99) < 8)
      frame_syms[$urandom_range(0, tsfd_pkg::FRAME_LEN - 1)] = tsfd_pkg::SYM_ERR;
  endfunction

  task automatic send_symbols(int n);
    for (int i = 0; i < n; i++) send_pulse(ticks_for(frame_syms[i]));
  endtask

  task automatic send_frame_sequence();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      build_frame();
      send_symbols(tsfd_pkg::FRAME_LEN);
      send_pulse(ticks_for(tsfd_pkg::SYM_SYNC));
    end else if (pick < 78) begin
      // sync before the frame is full
      build_frame();
      send_symbols($urandom_range(0, tsfd_pkg::FRAME_LEN - 1));
      send_pulse(ticks_for(tsfd_pkg::SYM_SYNC));
    end else if (pick < 86) begin
      // missed sync: the next frame starts over the full one
      foreach (frame_syms[i])
        frame_syms[i] = ($urandom_range(0, 9) == 0) ? tsfd_pkg::SYM_ERR
                                                     : bit_sym($urandom_range(0, 1));
      send_symbols(tsfd_pkg::FRAME_LEN);
      build_frame();
      send_symbols(tsfd_pkg::FRAME_LEN);
      send_pulse(ticks_for(tsfd_pkg::SYM_SYNC));
    end else if (pick < 93) begin
      build_frame();
      send_symbols(tsfd_pkg::FRAME_LEN - 1);
      send_pulse(ticks_for(tsfd_pkg::SYM_SYNC));
    end else begin
      repeat ($urandom_range(5, 30)) send_pulse(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(int p);
    logic [7:0] s, o;
    bit d;
    drain_results();
    d = p[1];
    if (p % 4 == 3) begin
      case ((p / 4) % 4)
        0: begin s = 8'd0; o = 8'd0; end
        1: begin s = 8'd255; o = 8'd255; end
        2: begin s = 8'd255; o = 8'd0; end
        default: begin s = 8'd0; o = 8'd255; end
      endcase
    end else if (p % 4 == 0) begin
      s = tsfd_pkg::SYNC_LIMIT_RST;
      o = tsfd_pkg::ONE_LIMIT_RST;
    end else begin
      s = 8'($urandom_range(1, 100));
      o = 8'($urandom_range(254, s + 2));
    end
    write_reg(tsfd_pkg::REG_SYNC_LIMIT, s);
    write_reg(tsfd_pkg::REG_ONE_LIMIT, o);
    write_reg(tsfd_pkg::REG_DATE_PARITY, {7'($urandom_range(0, 127)), d});
    if ($urandom_range(0, 1)) write_reg(tsfd_pkg::REG_UNUSED, 8'($urandom_range(0, 255)));
    cfg_ch.valid <= 1'b0;
    if (p % 4 == 3) begin
      send_pulse(s);
      send_pulse(o);
      repeat (40) send_pulse(8'($urandom_range(0, 255)));
    end else begin
      send_frame_sequence();
    end
  endtask

  initial begin : stimulus
    int phase;
    logic [7:0] edge_ticks[$];
    rst <= 1'b1;
    pulses_sent = 0;
    pulse_ch.valid <= 1'b0;
    pulse_ch.pulse_ticks <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= tsfd_pkg::REG_SYNC_LIMIT;
    cfg_ch.data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // class boundaries at reset limits, then back-to-back early syncs
    edge_ticks = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd29, 8'd30, 8'd31, 8'd128, 8'd127,
                   8'd254, 8'd255, 8'd0, 8'd0};
    foreach (edge_ticks[i]) send_pulse(edge_ticks[i]);

    phase = 0;
    while (pulses_sent < 1000 || phase < 16) begin
      run_phase(phase);
      phase++;
    end

    drain_results();
    repeat (5) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
